FILE: hdl/rmic_pkg.sv
`default_nettype none
package rmic_pkg;

    localparam int MAX_AXES_DEF       = 3;
    localparam int AXIS_SIZE_BITS_DEF = 16;
    localparam int FIELD_AXES         = 3;
    localparam int INDEX_W            = 16;
    localparam int OFFSET_W           = 48;
    localparam int CFG_W              = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int IN_TDATA_W         = 104;
    localparam int OUT_TDATA_W        = 104;

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_INV = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_AXES   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_OFFSET = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_COUNT = 2'd0,
        REG_AXIS0_SIZE = 2'd1,
        REG_AXIS1_SIZE = 2'd2,
        REG_AXIS2_SIZE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic    kind;
        status_t status;
    } ctl_t;

endpackage
`default_nettype wire

FILE: hdl/rmic_out_buf.sv
`default_nettype none
module rmic_out_buf #(
    parameter int W = rmic_pkg::OUT_TDATA_W
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic         out_vld_reg;
    logic         skid_vld_reg;
    logic [W-1:0] out_reg;
    logic [W-1:0] skid_reg;

    assign in_ready  = !skid_vld_reg;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : in_data;
        end
        else if (in_valid && !skid_vld_reg)
        begin
            skid_reg <= in_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry without output entry");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !out_ready))
        else $error("skid filled without output stall");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg && $stable(out_reg))
        else $error("output changed while stalled");

endmodule
`default_nettype wire

FILE: hdl/row_major_index_converter_unit.sv
`default_nettype none
// Row-major index converter: kind 0 turns a coordinate of up to three axes into its
// row-major element offset, kind 1 turns an offset back into a coordinate, using the
// axis count and sizes written on the configuration port; the user must write them only
// while the block is idle, which the block itself does not enforce. One item is accepted
// every cycle unless the skid entry of the output buffer is full. The restoring divider,
// one quotient bit per pipeline stage, splits the offset by the axis strides. A two-entry
// output buffer lets input keep flowing while one result waits on the output. The sizes
// reach the input checks directly; the strides and the total follow them in registers.
module row_major_index_converter_unit #(
    parameter int MAX_AXES       = rmic_pkg::MAX_AXES_DEF,
    parameter int AXIS_SIZE_BITS = rmic_pkg::AXIS_SIZE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rmic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rmic_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // given_axes, index_a, index_b, index_c, offset_in, zero pad
    input  wire logic [rmic_pkg::IN_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // offset_out, coord_a, coord_b, coord_c, status, zero pad
    output logic [rmic_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import rmic_pkg::*;

    localparam int SIZE_W   = (AXIS_SIZE_BITS > INDEX_W) ? INDEX_W : AXIS_SIZE_BITS;
    localparam int QA_STEPS = SIZE_W;
    localparam int QB_STEPS = SIZE_W;
    localparam int FRONT    = 3;
    localparam int NSTG     = FRONT + QA_STEPS + QB_STEPS;
    localparam int PAD_W    = OUT_TDATA_W - OFFSET_W - 3 * INDEX_W - 2;

    typedef struct packed {
        ctl_t                  ctl;
        logic [OFFSET_W-1:0]   offset;
        logic [OFFSET_W-1:0]   rem;
        logic [2*INDEX_W-1:0]  part1;
        logic [INDEX_W-1:0]    idx_c;
        logic [INDEX_W-1:0]    qa;
        logic [INDEX_W-1:0]    qb;
    } stage_t;

    logic [1:0]            axis_count_reg;
    logic [SIZE_W-1:0]     size_reg [FIELD_AXES];
    logic [2*INDEX_W-1:0]  stride0_reg;
    logic [OFFSET_W-1:0]   total_reg;
    logic [1:0]            act_axes;
    logic [INDEX_W-1:0]    eff_size [FIELD_AXES];

    logic                  vld_reg  [NSTG];
    stage_t                stg_reg  [NSTG];
    stage_t                stg_next [NSTG];
    logic                  adv;

    logic [1:0]            in_given;
    logic [INDEX_W-1:0]    in_a;
    logic [INDEX_W-1:0]    in_b;
    logic [INDEX_W-1:0]    in_c;
    logic [OFFSET_W-1:0]   in_off;
    logic [OUT_TDATA_W-1:0] res_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= 2'd1;
            for (int i = 0; i < FIELD_AXES; i++)
            begin
                size_reg[i] <= SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_AXIS_COUNT: axis_count_reg <= cfg_data[1:0];
                REG_AXIS0_SIZE: size_reg[0]    <= cfg_data[SIZE_W-1:0];
                REG_AXIS1_SIZE: size_reg[1]    <= cfg_data[SIZE_W-1:0];
                REG_AXIS2_SIZE: size_reg[2]    <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [INDEX_W-1:0] raw;
        act_axes = (axis_count_reg == 2'd0) ? 2'd1 : axis_count_reg;
        if (int'(act_axes) > MAX_AXES)
        begin
            act_axes = 2'(MAX_AXES);
        end
        for (int i = 0; i < FIELD_AXES; i++)
        begin
            raw = INDEX_W'(size_reg[i]);
            if (i < int'(act_axes))
            begin
                eff_size[i] = (raw == '0) ? INDEX_W'(1) : raw;
            end
            else
            begin
                eff_size[i] = INDEX_W'(1);
            end
        end
    end

    // strides follow the configuration: stride0_reg is registered from the sizes, total_reg from stride0_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride0_reg <= (2*INDEX_W)'(1);
            total_reg   <= OFFSET_W'(1);
        end
        else
        begin
            stride0_reg <= (2*INDEX_W)'(eff_size[1]) * (2*INDEX_W)'(eff_size[2]);
            total_reg   <= OFFSET_W'(stride0_reg) * OFFSET_W'(eff_size[0]);
        end
    end

    assign in_given = s_tdata[1:0];
    assign in_a     = s_tdata[17:2];
    assign in_b     = s_tdata[33:18];
    assign in_c     = s_tdata[49:34];
    assign in_off   = s_tdata[97:50];

    always_comb
    begin
        stage_t             p;
        logic [OFFSET_W-1:0] trial;
        int                 j;
        for (int s = 0; s < NSTG; s++)
        begin
            stg_next[s] = stg_reg[(s == 0) ? 0 : s - 1];
        end

        // check and mask the coordinate
        p            = '0;
        p.ctl.kind   = s_tuser;
        p.ctl.status = ST_OK;
        p.qa         = (in_given >= 2'd1) ? in_a : '0;
        p.qb         = (in_given >= 2'd2) ? in_b : '0;
        p.idx_c      = (in_given >= 2'd3) ? in_c : '0;
        p.rem        = in_off;
        if (s_tuser == KIND_FWD)
        begin
            if (in_given > act_axes)
                p.ctl.status = ST_AXES;
            else if (in_given >= 2'd1 && in_a >= eff_size[0])
                p.ctl.status = ST_RANGE;
            else if (in_given >= 2'd2 && in_b >= eff_size[1])
                p.ctl.status = ST_RANGE;
            else if (in_given >= 2'd3 && in_c >= eff_size[2])
                p.ctl.status = ST_RANGE;
        end
        stg_next[0] = p;

        // partial products
        p        = stg_reg[0];
        p.offset = OFFSET_W'(p.qa) * OFFSET_W'(stride0_reg);
        p.part1  = (2*INDEX_W)'(p.qb) * (2*INDEX_W)'(eff_size[2]);
        stg_next[1] = p;

        // sum, offset range check, clear unused fields
        p = stg_reg[1];
        if (p.ctl.kind == KIND_FWD)
        begin
            if (p.ctl.status == ST_OK)
                p.offset = p.offset + OFFSET_W'(p.part1) + OFFSET_W'(p.idx_c);
            else
                p.offset = '0;
            p.rem = '0;
        end
        else
        begin
            p.offset = '0;
            if (p.rem >= total_reg)
            begin
                p.ctl.status = ST_OFFSET;
                p.rem        = '0;
            end
        end
        p.qa    = '0;
        p.qb    = '0;
        p.idx_c = '0;
        stg_next[2] = p;

        // restoring division, one quotient bit per stage
        for (int k = 0; k < QA_STEPS; k++)
        begin
            p     = stg_reg[FRONT + k - 1];
            j     = QA_STEPS - 1 - k;
            trial = OFFSET_W'(stride0_reg) << j;
            if (p.rem >= trial)
            begin
                p.rem   = p.rem - trial;
                p.qa[j] = 1'b1;
            end
            stg_next[FRONT + k] = p;
        end
        for (int k = 0; k < QB_STEPS; k++)
        begin
            p     = stg_reg[FRONT + QA_STEPS + k - 1];
            j     = QB_STEPS - 1 - k;
            trial = OFFSET_W'(eff_size[2]) << j;
            if (p.rem >= trial)
            begin
                p.rem   = p.rem - trial;
                p.qb[j] = 1'b1;
            end
            stg_next[FRONT + QA_STEPS + k] = p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int s = 1; s < NSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign s_tready = adv;

    assign res_data = {PAD_W'(0), stg_reg[NSTG-1].ctl.status,
                       stg_reg[NSTG-1].rem[INDEX_W-1:0],
                       stg_reg[NSTG-1].qb, stg_reg[NSTG-1].qa,
                       stg_reg[NSTG-1].offset};

    rmic_out_buf #(
        .W (OUT_TDATA_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NSTG-1]),
        .in_ready  (adv),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[97:96] != ST_OK) |-> (m_tdata[95:0] == '0))
        else $error("error result carries nonzero fields");

    a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[47:0] != '0) |-> (m_tdata[95:48] == '0))
        else $error("offset and coordinate both nonzero");

    a_axes_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRONT-1] && (stg_reg[FRONT-1].ctl.status == ST_AXES ||
        stg_reg[FRONT-1].ctl.status == ST_RANGE) |-> stg_reg[FRONT-1].ctl.kind == KIND_FWD)
        else $error("coordinate error on inverse item");

    a_offset_inv: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRONT-1] && stg_reg[FRONT-1].ctl.status == ST_OFFSET
        |-> stg_reg[FRONT-1].ctl.kind == KIND_INV)
        else $error("offset error on forward item");

endmodule
`default_nettype wire
